FILE: hdl/assert_macros.svh
// Assertion helpers for the fragmentation planner.
// Simulation builds get the checks; synthesis builds define SYNTH and get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hdl/ipv4fp_pkg.sv
`default_nettype none

package ipv4fp_pkg;

  localparam int unsigned MtuW   = 16;
  localparam int unsigned P1W    = 6;
  localparam int unsigned P2W    = 16;
  localparam int unsigned OffW   = 13;
  localparam int unsigned PosW   = 17;
  localparam int unsigned KindW  = 2;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 72;

  localparam logic [PosW-1:0] SmallLimit = 17'd1260;
  localparam logic [MtuW-1:0] MinV6Mtu   = 16'd1280;
  localparam logic [OffW:0]   MaxOffset  = 14'd8191;
  localparam logic [MtuW-1:0] HdrLen     = 16'd20;
  localparam logic [MtuW-1:0] MinMtu     = 16'd68;
  localparam logic [MtuW-1:0] MtuReset   = 16'd1500;

  typedef enum logic [KindW-1:0] {
    KIND_SEND    = 2'd0,
    KIND_TOO_BIG = 2'd1,
    KIND_DROP    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_PART1,
    ST_PART2,
    ST_FRAG
  } state_t;

  typedef enum logic [1:0] {
    EM_WHOLE,
    EM_REPORT,
    EM_DROP,
    EM_FRAG
  } emit_sel_t;

  typedef struct packed {
    logic      load_in;
    logic      latch_maxf;
    logic      load_p1;
    logic      load_p2;
    logic      emit;
    emit_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic small_pkt;
    logic fits;
    logic frag_bad;
    logic p1_zero;
    logic p2_zero;
    logic p2_bad;
    logic off_over;
    logic frag_final;
    logic in_part2;
    logic out_free;
  } status_t;

  typedef struct packed {
    kind_t           kind;
    logic            df_flag;
    logic            mf_flag;
    logic [OffW-1:0] frag_off;
    logic [PosW-1:0] payload_start;
    logic [PosW-1:0] payload_length;
    logic [MtuW-1:0] reported_mtu;
    logic            last;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hdl/ipv4fp_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module ipv4fp_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  ipv4fp_pkg::status_t  sts,
  output ipv4fp_pkg::cmd_t     cmd
);

  ipv4fp_pkg::state_t state;
  ipv4fp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipv4fp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ipv4fp_pkg::ST_IDLE: begin
        if (in_valid) state_next = ipv4fp_pkg::ST_CLASSIFY;
      end
      ipv4fp_pkg::ST_CLASSIFY: begin
        if (sts.small_pkt && !sts.fits && !sts.frag_bad) begin
          state_next = ipv4fp_pkg::ST_PART1;
        end else if (sts.out_free) begin
          state_next = ipv4fp_pkg::ST_IDLE;
        end
      end
      ipv4fp_pkg::ST_PART1: begin
        state_next = sts.p1_zero ? ipv4fp_pkg::ST_PART2 : ipv4fp_pkg::ST_FRAG;
      end
      ipv4fp_pkg::ST_PART2: begin
        if (sts.p2_zero) begin
          state_next = ipv4fp_pkg::ST_IDLE;
        end else if (sts.p2_bad) begin
          if (sts.out_free) state_next = ipv4fp_pkg::ST_IDLE;
        end else begin
          state_next = ipv4fp_pkg::ST_FRAG;
        end
      end
      ipv4fp_pkg::ST_FRAG: begin
        if (sts.out_free) begin
          if (sts.off_over) begin
            state_next = ipv4fp_pkg::ST_IDLE;
          end else if (sts.frag_final) begin
            state_next = sts.in_part2 ? ipv4fp_pkg::ST_IDLE : ipv4fp_pkg::ST_PART2;
          end
        end
      end
      default: state_next = ipv4fp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd.load_in    = 1'b0;
    cmd.latch_maxf = 1'b0;
    cmd.load_p1    = 1'b0;
    cmd.load_p2    = 1'b0;
    cmd.emit       = 1'b0;
    cmd.sel        = ipv4fp_pkg::EM_DROP;
    unique case (state)
      ipv4fp_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ipv4fp_pkg::ST_CLASSIFY: begin
        cmd.latch_maxf = 1'b1;
        if (sts.small_pkt && sts.fits) begin
          cmd.emit = sts.out_free;
          cmd.sel  = ipv4fp_pkg::EM_WHOLE;
        end else if (sts.small_pkt) begin
          cmd.emit = sts.frag_bad && sts.out_free;
          cmd.sel  = ipv4fp_pkg::EM_DROP;
        end else begin
          cmd.emit = sts.out_free;
          cmd.sel  = sts.fits ? ipv4fp_pkg::EM_WHOLE : ipv4fp_pkg::EM_REPORT;
        end
      end
      ipv4fp_pkg::ST_PART1: begin
        cmd.load_p1 = !sts.p1_zero;
      end
      ipv4fp_pkg::ST_PART2: begin
        if (!sts.p2_zero) begin
          if (sts.p2_bad) begin
            cmd.emit = sts.out_free;
            cmd.sel  = ipv4fp_pkg::EM_DROP;
          end else begin
            cmd.load_p2 = 1'b1;
          end
        end
      end
      ipv4fp_pkg::ST_FRAG: begin
        cmd.emit = sts.out_free;
        cmd.sel  = sts.off_over ? ipv4fp_pkg::EM_DROP : ipv4fp_pkg::EM_FRAG;
      end
      default: begin
      end
    endcase
  end

  `ASSERT_CLK(a_emit_needs_slot, clk, rst, cmd.emit |-> sts.out_free, "emit with output full")
  `ASSERT_CLK(a_p2_load_aligned, clk, rst, cmd.load_p2 |-> !sts.p2_bad, "bad part two loaded")

endmodule

`default_nettype wire

FILE: hdl/ipv4fp_datapath.sv
`default_nettype none

`include "assert_macros.svh"

module ipv4fp_datapath (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_wr_en,
  input  wire  [ipv4fp_pkg::MtuW-1:0]         cfg_wr_data,
  input  wire  [ipv4fp_pkg::P1W-1:0]          first_part_length,
  input  wire  [ipv4fp_pkg::P2W-1:0]          second_part_length,
  input  wire                                 mf_in,
  input  wire  [ipv4fp_pkg::OffW-1:0]         frag_off_in,
  input  ipv4fp_pkg::cmd_t                    cmd,
  output ipv4fp_pkg::status_t                 sts,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output ipv4fp_pkg::out_item_t               out_item
);

  localparam int unsigned PosW = ipv4fp_pkg::PosW;
  localparam int unsigned MtuW = ipv4fp_pkg::MtuW;
  localparam int unsigned OffW = ipv4fp_pkg::OffW;

  logic [MtuW-1:0]             mtu;
  logic [ipv4fp_pkg::P1W-1:0]  p1;
  logic [ipv4fp_pkg::P2W-1:0]  p2;
  logic                        mfin;
  logic [OffW:0]               off;
  logic [PosW-1:0]             total;
  logic [MtuW-1:0]             maxf;
  logic [PosW-1:0]             size;
  logic [PosW-1:0]             start;
  logic                        part_mf;
  logic                        in_part2;

  logic [MtuW-1:0]             mtu_less_hdr;
  logic [MtuW-1:0]             rep_raw;
  logic [MtuW-1:0]             rep;
  logic [PosW-1:0]             maxf_ext;
  logic [PosW-1:0]             take;
  logic                        frag_final;
  logic [PosW-1:0]             whole_len;
  ipv4fp_pkg::out_item_t       item_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mtu <= ipv4fp_pkg::MtuReset;
    end else if (cfg_wr_en) begin
      mtu <= cfg_wr_data;
    end
  end

  assign mtu_less_hdr = mtu - ipv4fp_pkg::HdrLen;
  assign maxf_ext     = {1'b0, maxf};
  assign frag_final   = size <= maxf_ext;
  assign take         = frag_final ? size : maxf_ext;
  assign whole_len    = PosW'(p1) + PosW'(p2);
  assign rep_raw      = mtu + ipv4fp_pkg::HdrLen;
  assign rep          = (rep_raw < ipv4fp_pkg::MinV6Mtu) ? ipv4fp_pkg::MinV6Mtu : rep_raw;

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      p1    <= first_part_length;
      p2    <= second_part_length;
      mfin  <= mf_in;
      off   <= {1'b0, frag_off_in};
      total <= PosW'(ipv4fp_pkg::HdrLen) + PosW'(first_part_length)
               + PosW'(second_part_length);
    end else if (cmd.emit && cmd.sel == ipv4fp_pkg::EM_FRAG) begin
      off <= off + (OffW+1)'(take >> 3);
    end
    if (cmd.latch_maxf) begin
      maxf <= {mtu_less_hdr[MtuW-1:3], 3'b000};
    end
    if (cmd.load_p1) begin
      size     <= PosW'(p1);
      start    <= '0;
      part_mf  <= (p2 != '0) | mfin;
      in_part2 <= 1'b0;
    end else if (cmd.load_p2) begin
      size     <= PosW'(p2);
      start    <= PosW'(p1);
      part_mf  <= mfin;
      in_part2 <= 1'b1;
    end else if (cmd.emit && cmd.sel == ipv4fp_pkg::EM_FRAG) begin
      size  <= size - take;
      start <= start + take;
    end
  end

  always_comb begin
    sts.small_pkt  = total <= ipv4fp_pkg::SmallLimit;
    sts.fits       = total <= PosW'(mtu);
    sts.frag_bad   = (p1[2:0] != 3'b000) || (mtu < ipv4fp_pkg::MinMtu);
    sts.p1_zero    = p1 == '0;
    sts.p2_zero    = p2 == '0;
    sts.p2_bad     = mfin && (p2[2:0] != 3'b000);
    sts.off_over   = off > ipv4fp_pkg::MaxOffset;
    sts.frag_final = frag_final;
    sts.in_part2   = in_part2;
    sts.out_free   = !out_valid || out_ready;
  end

  // result mux
  always_comb begin
    item_next                = '0;
    item_next.kind           = ipv4fp_pkg::KIND_DROP;
    item_next.last           = 1'b1;
    unique case (cmd.sel)
      ipv4fp_pkg::EM_WHOLE: begin
        item_next.kind           = ipv4fp_pkg::KIND_SEND;
        item_next.df_flag        = !sts.small_pkt;
        item_next.mf_flag        = mfin;
        item_next.frag_off       = off[OffW-1:0];
        item_next.payload_length = whole_len;
      end
      ipv4fp_pkg::EM_REPORT: begin
        item_next.kind         = ipv4fp_pkg::KIND_TOO_BIG;
        item_next.reported_mtu = rep;
      end
      ipv4fp_pkg::EM_DROP: begin
        item_next.kind = ipv4fp_pkg::KIND_DROP;
      end
      ipv4fp_pkg::EM_FRAG: begin
        item_next.kind           = ipv4fp_pkg::KIND_SEND;
        item_next.mf_flag        = !frag_final || part_mf;
        item_next.frag_off       = off[OffW-1:0];
        item_next.payload_start  = start;
        item_next.payload_length = take;
        item_next.last           = frag_final && (in_part2 || sts.p2_zero);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item <= item_next;
    end
  end

  `ASSERT_CLK(a_frag_size, clk, rst, (cmd.emit && cmd.sel == ipv4fp_pkg::EM_FRAG) |-> (take != '0 && take <= maxf_ext), "fragment size out of range")
  `ASSERT_CLK(a_frag_offset, clk, rst, (cmd.emit && cmd.sel == ipv4fp_pkg::EM_FRAG) |-> !off[OffW], "fragment offset overflow")

endmodule

`default_nettype wire

FILE: hdl/ipv4_fragmentation_planner.sv
`default_nettype none

// IPv4 fragmentation planner: one input transfer describes a translated packet,
// the block answers with its send plan, one result transfer per packet/fragment.
// Input s_axis: first/second part lengths, incoming MF and fragment offset.
// Output m_axis: kind in tuser, last result of a plan on tlast, the rest in tdata.
// Config: cfg_wr_en/cfg_wr_data write the outbound MTU (reset value 1500); the user
// must write it only while idle, the block itself does not enforce it.
// A result is registered from the classify state; fragmented plans pass the
// part-one setup state, then emit one fragment per cycle while the output is
// free; a second part adds the part-two setup state.
// The plan sequencer handles one item at a time; a new input is taken once it is
// back in idle with the previous plan's last result in the output register.
// Reset: synchronous, clears the sequencer and output valid, MTU goes to 1500.
// Stall: while m_axis_tready is low the result register holds and the sequencer
// waits; no result is lost or repeated.

module ipv4_fragmentation_planner (
  input  wire                                clk,
  input  wire                                rst,
  // configuration
  input  wire                                cfg_wr_en,
  input  wire  [ipv4fp_pkg::MtuW-1:0]        cfg_wr_data,
  // input stream
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // [5:0] first_part_length, [21:6] second_part_length, [22] incoming MF,
  // [35:23] incoming offset, [39:36] zero
  input  wire  [ipv4fp_pkg::InDataW-1:0]     s_axis_tdata,
  // result stream
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // [0] DF flag, [1] MF flag, [14:2] offset,
  // [31:15] payload_start, [48:32] payload_length, [64:49] reported_mtu,
  // [71:65] zero
  output logic [ipv4fp_pkg::OutDataW-1:0]    m_axis_tdata,
  // [1:0] kind
  output logic [ipv4fp_pkg::KindW-1:0]       m_axis_tuser,
  output logic                               m_axis_tlast
);

  ipv4fp_pkg::cmd_t      cmd;
  ipv4fp_pkg::status_t   sts;
  ipv4fp_pkg::out_item_t out_item;

  ipv4fp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // input field unpacking straight into the datapath
  ipv4fp_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .first_part_length  (s_axis_tdata[5:0]),
    .second_part_length (s_axis_tdata[21:6]),
    .mf_in              (s_axis_tdata[22]),
    .frag_off_in        (s_axis_tdata[35:23]),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (m_axis_tvalid),
    .out_ready          (m_axis_tready),
    .out_item           (out_item)
  );

  // pack the result register onto the stream
  assign m_axis_tdata = {7'b0000000,
                         out_item.reported_mtu,
                         out_item.payload_length,
                         out_item.payload_start,
                         out_item.frag_off,
                         out_item.mf_flag,
                         out_item.df_flag};
  assign m_axis_tuser = out_item.kind;
  assign m_axis_tlast = out_item.last;

endmodule

`default_nettype wire

FILE: bench/tb_ipv4_fragmentation_planner.sv
`default_nettype none

module tb_ipv4_fragmentation_planner;

  localparam int unsigned MtuW     = ipv4fp_pkg::MtuW;
  localparam int unsigned P1W      = ipv4fp_pkg::P1W;
  localparam int unsigned P2W      = ipv4fp_pkg::P2W;
  localparam int unsigned OffW     = ipv4fp_pkg::OffW;
  localparam int unsigned PosW     = ipv4fp_pkg::PosW;
  localparam int unsigned KindW    = ipv4fp_pkg::KindW;
  localparam int unsigned InDataW  = ipv4fp_pkg::InDataW;
  localparam int unsigned OutDataW = ipv4fp_pkg::OutDataW;

  localparam logic [PosW-1:0] SmallLimit = ipv4fp_pkg::SmallLimit;
  localparam logic [MtuW-1:0] MinV6Mtu   = ipv4fp_pkg::MinV6Mtu;
  localparam logic [OffW:0]   MaxOffset  = ipv4fp_pkg::MaxOffset;
  localparam logic [MtuW-1:0] HdrLen     = ipv4fp_pkg::HdrLen;
  localparam logic [MtuW-1:0] MinMtu     = ipv4fp_pkg::MinMtu;
  localparam logic [MtuW-1:0] MtuReset   = ipv4fp_pkg::MtuReset;

  // fragment sizes and offsets move in 8-byte units
  localparam int unsigned FragUnit = 8;
  // cycles allowed for the block to go quiet after the last result
  localparam int unsigned SettleCycles = 12;
  // long receiver hold-off used to fill the block and stall its input
  localparam int unsigned HoldCycles = 400;
  // cycles with no transfer on either stream before the run is called hung
  localparam int unsigned StallLimit = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                cfg_wr_en = 1'b0;
  logic [MtuW-1:0]     cfg_wr_data = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [KindW-1:0]    m_axis_tuser;
  logic                m_axis_tlast;

  ipv4_fragmentation_planner dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Send-plan predictor. Our copy of the MTU register tracks every write; the
  // planned results of each accepted packet are queued in arrival order.
  // ---------------------------------------------------------------------------
  logic [MtuW-1:0]       link_mtu = MtuReset;
  ipv4fp_pkg::out_item_t plan_q[$];
  int unsigned           err_count = 0;

  // knobs shared by the stimulus and the receiver
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests = 0;

  function automatic void add_plan_entry(ipv4fp_pkg::kind_t k, logic df, logic mf,
                                         int unsigned off, int unsigned start,
                                         int unsigned len, int unsigned rmtu);
    ipv4fp_pkg::out_item_t e;
    e.kind           = k;
    e.df_flag        = df;
    e.mf_flag        = mf;
    e.frag_off       = OffW'(off);
    e.payload_start  = PosW'(start);
    e.payload_length = PosW'(len);
    e.reported_mtu   = MtuW'(rmtu);
    e.last           = 1'b0;
    plan_q.push_back(e);
  endfunction

  // Cuts one part into fragments of at most max_frag bytes. Returns 0 when the
  // run has to stop (ragged part with MF, or offset past the 13-bit range).
  function automatic bit plan_part(int unsigned start, int unsigned size,
                                   inout int unsigned off, input logic part_mf,
                                   input int unsigned max_frag);
    int unsigned take;
    if (part_mf && (size % FragUnit) != 0) return 1'b0;
    while (size > 0) begin
      take = (size < max_frag) ? size : max_frag;
      if (off > MaxOffset) return 1'b0;
      add_plan_entry(ipv4fp_pkg::KIND_SEND, 1'b0, (size > max_frag) ? 1'b1 : part_mf,
                     off, start, take, 0);
      start += take;
      size  -= take;
      off   += take / FragUnit;
    end
    return 1'b1;
  endfunction

  function automatic void plan_packet(logic [P1W-1:0] p1, logic [P2W-1:0] p2,
                                      logic mf_in, logic [OffW-1:0] off_in);
    int unsigned mtu, total, max_frag, off, rep;
    bit ok;
    mtu   = link_mtu;
    total = HdrLen + p1 + p2;
    if (total <= SmallLimit) begin
      if (total <= mtu) begin
        add_plan_entry(ipv4fp_pkg::KIND_SEND, 1'b0, mf_in, off_in, 0, p1 + p2, 0);
      end else if ((p1 % FragUnit) != 0 || mtu < MinMtu) begin
        add_plan_entry(ipv4fp_pkg::KIND_DROP, 1'b0, 1'b0, 0, 0, 0, 0);
      end else begin
        max_frag = mtu - HdrLen;
        max_frag -= max_frag % FragUnit;
        off = off_in;
        ok  = 1'b1;
        // first part carries MF whenever a second part follows it
        if (p1 > 0) ok = plan_part(0, p1, off, (p2 > 0) ? 1'b1 : mf_in, max_frag);
        if (!ok) begin
          add_plan_entry(ipv4fp_pkg::KIND_DROP, 1'b0, 1'b0, 0, 0, 0, 0);
        end else if (p2 > 0) begin
          if (!plan_part(p1, p2, off, mf_in, max_frag))
            add_plan_entry(ipv4fp_pkg::KIND_DROP, 1'b0, 1'b0, 0, 0, 0, 0);
        end
      end
    end else if (total > mtu) begin
      // too-big report quotes the IPv6-side MTU, floored at the IPv6 minimum
      rep = (mtu + HdrLen) % 65536;
      if (rep < MinV6Mtu) rep = MinV6Mtu;
      add_plan_entry(ipv4fp_pkg::KIND_TOO_BIG, 1'b0, 1'b0, 0, 0, 0, rep);
    end else begin
      add_plan_entry(ipv4fp_pkg::KIND_SEND, 1'b1, mf_in, off_in, 0, p1 + p2, 0);
    end
    plan_q[plan_q.size() - 1].last = 1'b1;
  endfunction

  function automatic string item_str(ipv4fp_pkg::out_item_t i);
    return $sformatf("kind=%0d df=%0b mf=%0b off=%0d start=%0d len=%0d rmtu=%0d last=%0b",
                     i.kind, i.df_flag, i.mf_flag, i.frag_off,
                     i.payload_start, i.payload_length, i.reported_mtu, i.last);
  endfunction

  // ---------------------------------------------------------------------------
  // Input monitor: every accepted packet transfer is planned here.
  // tdata: [5:0] p1, [21:6] p2, [22] MF in, [35:23] offset in.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      plan_packet(s_axis_tdata[5:0], s_axis_tdata[21:6], s_axis_tdata[22],
                  s_axis_tdata[35:23]);
  end

  // ---------------------------------------------------------------------------
  // Result checker: each result transfer against the oldest planned entry.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    ipv4fp_pkg::out_item_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind           = ipv4fp_pkg::kind_t'(m_axis_tuser);
      got.df_flag        = m_axis_tdata[0];
      got.mf_flag        = m_axis_tdata[1];
      got.frag_off       = m_axis_tdata[14:2];
      got.payload_start  = m_axis_tdata[31:15];
      got.payload_length = m_axis_tdata[48:32];
      got.reported_mtu   = m_axis_tdata[64:49];
      got.last           = m_axis_tlast;
      if (plan_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("[%0t] unexpected result: %s", $realtime, item_str(got));
      end else begin
        want = plan_q.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10)
            $display("[%0t] mismatch\n  expected %s\n  actual   %s", $realtime,
                     item_str(want), item_str(got));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls at recv_stall_pct; a bumped hold_requests forces a
  // long hold-off so the planner backs up into its input.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned served;
    served = 0;
    forever begin
      @(posedge clk);
      if (served != hold_requests) begin
        served = hold_requests;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hang detector: any cycle without a transfer on either stream counts.
  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= StallLimit) begin
        $display("timeout: no transfer for %0d cycles, %0d results pending",
                 StallLimit, plan_q.size());
        $display("tb_ipv4_fragmentation_planner: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offers one packet and holds it until taken; tvalid stays up when the next
  // packet follows at once, otherwise it drops for a random idle stretch.
  task automatic send_packet(input logic [P1W-1:0] p1, input logic [P2W-1:0] p2,
                             input logic mf, input logic [OffW-1:0] off);
    s_axis_tdata  <= {4'b0, off, mf, p2, p1};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Stops offering and waits until every planned result has come out.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (plan_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Only called with the block idle (after a drain).
  task automatic write_mtu(input logic [MtuW-1:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    link_mtu     = value;
  endtask

  function automatic logic [MtuW-1:0] pick_mtu();
    case ($urandom_range(7))
      0:       return MtuW'($urandom_range(MinMtu - 1));  // unusable for fragments
      1:       return MinMtu;
      2:       return MtuW'($urandom_range(600, MinMtu + 1));
      3:       return 16'd576;
      4:       return MtuW'($urandom_range(1300, 1239));  // straddles the small limit
      5:       return MinV6Mtu;
      6:       return 16'hFFFF;
      default: return MtuW'($urandom);
    endcase
  endfunction

  // Mostly well-formed packets under the small limit so fragmentation is hit
  // hard; the rest are ragged first parts and full-range second parts.
  task automatic send_random_packet;
    logic [P1W-1:0]  p1;
    logic [P2W-1:0]  p2;
    logic            mf;
    logic [OffW-1:0] off;
    int unsigned     pick;
    pick = $urandom_range(99);
    mf   = 1'($urandom_range(1));
    case ($urandom_range(3))
      0:       off = OffW'($urandom_range(8191, 8000));  // runs off the offset range
      1:       off = OffW'($urandom);
      default: off = OffW'($urandom_range(64));
    endcase
    if (pick < 60) begin
      p1 = P1W'(FragUnit * $urandom_range(5));
      p2 = P2W'($urandom_range(SmallLimit - HdrLen - p1));
      if (pick < 35) p2 = p2 & ~P2W'(FragUnit - 1);
    end else if (pick < 75) begin
      p1 = P1W'($urandom_range(63));
      p2 = P2W'($urandom_range(1200));
    end else begin
      p1 = P1W'($urandom_range(63));
      p2 = P2W'($urandom);
    end
    send_packet(p1, p2, mf, off);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every result kind and each corner of the fragmenter.
  task automatic test_directed_cases;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // reset MTU of 1500
    send_packet(6'd0,  16'd0,     1'b0, 13'd0);     // empty packet, sent whole
    send_packet(6'd40, 16'd1200,  1'b1, 13'd8191);  // exactly the small limit
    send_packet(6'd0,  16'd1241,  1'b0, 13'd5);     // just over: whole with DF
    send_packet(6'd63, 16'hFFFF,  1'b1, 13'd8191);  // too big, report MTU+20
    send_packet(6'd63, 16'd0,     1'b0, 13'd0);     // ragged first part that fits
    drain();
    write_mtu(16'd576);
    send_packet(6'd40, 16'd1000,  1'b0, 13'd0);     // plain fragmentation
    send_packet(6'd40, 16'd1001,  1'b1, 13'd100);   // ragged second part with MF
    send_packet(6'd12, 16'd1000,  1'b0, 13'd0);     // ragged first part
    send_packet(6'd0,  16'd1200,  1'b0, 13'd8190);  // offset overflows mid-run
    send_packet(6'd0,  16'd1001,  1'b0, 13'd3);     // ragged second part, no MF
    send_packet(6'd16, 16'd0,     1'b1, 13'd7);
    send_packet(6'd0,  16'd2000,  1'b0, 13'd0);     // report floored at 1280
    send_packet(6'd40, 16'd600,   1'b1, 13'd0);
    drain();
    write_mtu(16'd0);
    send_packet(6'd0,  16'd0,     1'b1, 13'd0);     // MTU below header: drop
    send_packet(6'd0,  16'd5000,  1'b0, 13'd0);
    drain();
    write_mtu(MinMtu - 16'd1);
    send_packet(6'd8,  16'd100,   1'b0, 13'd0);     // no usable fragment size
    drain();
    write_mtu(MinMtu);
    send_packet(6'd40, 16'd1200,  1'b0, 13'd0);     // longest fragment run
    send_packet(6'd40, 16'd1200,  1'b1, 13'd8180);
    send_packet(6'd40, 16'd0,     1'b1, 13'd0);
    drain();
    write_mtu(16'hFFFF);
    send_packet(6'd63, 16'hFFFF,  1'b1, 13'd1);     // report wraps, floored
    send_packet(6'd0,  16'd65515, 1'b1, 13'd4095);  // exactly the MTU, DF set
    drain();
    write_mtu(16'd1300);
    send_packet(6'd0,  16'd1500,  1'b0, 13'd0);     // report above the floor
    drain();
  endtask

  // Random packets over several MTUs at one idling setting.
  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int b = 0; b < 4; b++) begin
      write_mtu(pick_mtu());
      repeat (28) send_random_packet();
      drain();
    end
  endtask

  // Long output hold-off while fragment-heavy packets keep coming: the block
  // must back up, stall its input and lose nothing.
  task automatic test_output_backpressure;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_mtu(MinMtu);
    hold_requests++;
    repeat (20)
      send_packet(6'd40, P2W'($urandom_range(150) * FragUnit), 1'b0,
                  OffW'($urandom_range(100)));
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic(0, 0);
    test_random_traffic(81, 0);
    test_random_traffic(0, 81);
    test_random_traffic(20, 20);
    test_output_backpressure();
    write_mtu(MtuReset);
    if (err_count == 0 && plan_q.size() == 0) begin
      $display("tb_ipv4_fragmentation_planner: PASS");
    end else begin
      $display("tb_ipv4_fragmentation_planner: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
